// File: rtl/tty_ld_pkg.sv
// Shared types and constants for the terminal input line discipline.
// Holds register codes, reset values, character codes and the command and
// status structs that join the controller and the datapath. No dependencies.
`timescale 1ns / 1ps

package tty_ld_pkg;

	localparam int LINE_DEPTH_DEF = 16;
	localparam int MAX_RESULTS    = 48;
	// Each erased entry echoes three bytes, so the result limit bounds the erase count.
	localparam int ERASE_CAP      = MAX_RESULTS / 3;
	localparam int ECW            = $clog2(ERASE_CAP);
	localparam int CFG_IDX_W      = 3;

	localparam logic [2:0]  INPUT_MODE_RST   = 3'd3;
	localparam logic [5:0]  LOCAL_MODE_RST   = 6'd23;
	localparam logic [1:0]  OUTPUT_MODE_RST  = 2'd3;
	localparam logic [23:0] SIGNAL_CHARS_RST = 24'h1A1C03;
	localparam logic [31:0] EDIT_CHARS_RST   = 32'h04007F15;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_ZERO  = 8'h00;
	localparam logic [7:0] CTRL_BIT = 8'h40;

	localparam logic [1:0] SIG_INTR = 2'd0;
	localparam logic [1:0] SIG_QUIT = 2'd1;
	localparam logic [1:0] SIG_SUSP = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INPUT_MODE   = 3'd0,
		CFG_LOCAL_MODE   = 3'd1,
		CFG_OUTPUT_MODE  = 3'd2,
		CFG_SIGNAL_CHARS = 3'd3,
		CFG_EDIT_CHARS   = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_ECHO   = 2'd0,
		KIND_ENTRY  = 2'd1,
		KIND_SIGNAL = 2'd2
	} out_kind_t;

	typedef enum logic [3:0] {
		CL_FLUSH,
		CL_SIG,
		CL_RAW,
		CL_KILL,
		CL_ERASE,
		CL_EOL,
		CL_EOF,
		CL_NL,
		CL_CTRL,
		CL_PLAIN
	} class_t;

	typedef enum logic [2:0] {
		EM_SIG,
		EM_RAW,
		EM_CARET,
		EM_CR,
		EM_MAIN,
		EM_BS,
		EM_SP,
		EM_COMMIT
	} emit_sel_t;

	typedef struct packed {
		logic      load_item;
		logic      emit;
		emit_sel_t emit_sel;
		logic      emit_last;
		logic      store_first;
		logic      store_second;
		logic      len_dec;
		logic      len_clear;
		logic      idx_clear;
		logic      idx_inc;
	} dp_cmd_t;

	typedef struct packed {
		class_t cls;
		logic   echo_on;
		logic   echo_nl_on;
		logic   main_cr;
		logic   out_free;
		logic   len_zero;
		logic   len_one;
		logic   idx_last;
	} dp_status_t;

endpackage

// File: rtl/tty_ld_dp.sv
// Datapath of the line discipline: configuration registers, item register,
// byte classification, line store, length and commit index, output register.
// Depends on tty_ld_pkg; driven by commands from tty_ld_ctrl.
`timescale 1ns / 1ps

module tty_ld_dp import tty_ld_pkg::*; #(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 req_type,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           out_kind,
	output logic [7:0]           out_byte,
	output logic                 end_of_line,
	output logic [1:0]           signal_code,
	output logic                 last,
	input  dp_cmd_t              cmd,
	output dp_status_t           st
);

	localparam int LW = $clog2(LINE_DEPTH + 1);
	localparam int IW = $clog2(LINE_DEPTH);

	logic [2:0]  input_mode_q;
	logic [5:0]  local_mode_q;
	logic [1:0]  output_mode_q;
	logic [23:0] signal_chars_q;
	logic [31:0] edit_chars_q;

	logic        req_q;
	logic [7:0]  byte_q;

	logic [8:0]  line_q [LINE_DEPTH];
	logic [LW-1:0] len_q;
	logic [IW-1:0] idx_q;

	logic        out_valid_q;
	out_kind_t   out_kind_q;
	logic [7:0]  out_byte_q;
	logic        out_eol_q;
	logic [1:0]  out_code_q;
	logic        out_last_q;

	logic [7:0]  ch_s;
	logic [7:0]  ch_m;
	logic        hit_int;
	logic        hit_quit;
	logic        hit_susp;
	logic [1:0]  sig_code;
	class_t      cls;
	logic [7:0]  main_byte;
	logic [8:0]  first_entry;
	logic [8:0]  second_entry;
	logic [8:0]  commit_entry;
	logic        full;
	logic        do_store;
	logic        emit_ok;

	out_kind_t   em_kind;
	logic [7:0]  em_byte;
	logic        em_eol;
	logic [1:0]  em_code;

	// Configuration writes are accepted on every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_mode_q   <= INPUT_MODE_RST;
			local_mode_q   <= LOCAL_MODE_RST;
			output_mode_q  <= OUTPUT_MODE_RST;
			signal_chars_q <= SIGNAL_CHARS_RST;
			edit_chars_q   <= EDIT_CHARS_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_INPUT_MODE:   input_mode_q   <= cfg_data[2:0];
				CFG_LOCAL_MODE:   local_mode_q   <= cfg_data[5:0];
				CFG_OUTPUT_MODE:  output_mode_q  <= cfg_data[1:0];
				CFG_SIGNAL_CHARS: signal_chars_q <= cfg_data[23:0];
				CFG_EDIT_CHARS:   edit_chars_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			req_q  <= req_type;
			byte_q <= rx_byte;
		end
	end

	// Classification of the held byte.
	always_comb begin
		ch_s = input_mode_q[0] ? {1'b0, byte_q[6:0]} : byte_q;

		hit_int  = ch_s == signal_chars_q[7:0];
		hit_quit = ch_s == signal_chars_q[15:8];
		hit_susp = ch_s == signal_chars_q[23:16];
		if (hit_int) begin
			sig_code = SIG_INTR;
		end else if (hit_quit) begin
			sig_code = SIG_QUIT;
		end else begin
			sig_code = SIG_SUSP;
		end

		if (ch_s == CH_CR && input_mode_q[1]) begin
			ch_m = CH_NL;
		end else if (ch_s == CH_NL && input_mode_q[2]) begin
			ch_m = CH_CR;
		end else begin
			ch_m = ch_s;
		end

		if (req_q) begin
			cls = CL_FLUSH;
		end else if (local_mode_q[0] && (hit_int || hit_quit || hit_susp)) begin
			cls = CL_SIG;
		end else if (!local_mode_q[1]) begin
			cls = CL_RAW;
		end else if (ch_m == edit_chars_q[7:0] && local_mode_q[3]) begin
			cls = CL_KILL;
		end else if (ch_m == edit_chars_q[15:8] && local_mode_q[4]) begin
			cls = CL_ERASE;
		end else if (ch_m == edit_chars_q[23:16]) begin
			cls = CL_EOL;
		end else if (ch_m == edit_chars_q[31:24]) begin
			cls = CL_EOF;
		end else if (ch_m == CH_NL) begin
			cls = CL_NL;
		end else if (!(ch_m inside {[CH_SPACE:CH_TILDE]})) begin
			cls = CL_CTRL;
		end else begin
			cls = CL_PLAIN;
		end

		main_byte = (cls == CL_CTRL) ? (ch_m | CTRL_BIT) : ch_m;

		case (cls)
			CL_EOF:  first_entry = {1'b1, CH_ZERO};
			CL_NL:   first_entry = {1'b1, CH_NL};
			CL_CTRL: first_entry = {1'b0, CH_CARET};
			default: first_entry = {1'b0, ch_m};
		endcase
		second_entry = {1'b0, ch_m | CTRL_BIT};
	end

	// Line store and its length. Bytes past the end of the store are dropped.
	assign full     = len_q >= LW'(LINE_DEPTH);
	assign do_store = (cmd.store_first || cmd.store_second) && !full;

	always_ff @(posedge clk) begin
		if (do_store) begin
			line_q[len_q[IW-1:0]] <= cmd.store_second ? second_entry : first_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.len_clear) begin
				len_q <= '0;
			end else if (cmd.len_dec) begin
				len_q <= len_q - LW'(1);
			end else if (do_store) begin
				len_q <= len_q + LW'(1);
			end
			if (cmd.idx_clear) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	assign commit_entry = line_q[idx_q];

	// Result selection.
	always_comb begin
		em_kind = KIND_ECHO;
		em_byte = CH_ZERO;
		em_eol  = 1'b0;
		em_code = SIG_INTR;
		case (cmd.emit_sel)
			EM_SIG: begin
				em_kind = KIND_SIGNAL;
				em_code = sig_code;
			end
			EM_RAW: begin
				em_kind = KIND_ENTRY;
				em_byte = ch_m;
			end
			EM_CARET:  em_byte = CH_CARET;
			EM_CR:     em_byte = CH_CR;
			EM_MAIN:   em_byte = main_byte;
			EM_BS:     em_byte = CH_BS;
			EM_SP:     em_byte = CH_SPACE;
			EM_COMMIT: begin
				em_kind = KIND_ENTRY;
				em_byte = commit_entry[7:0];
				em_eol  = commit_entry[8];
			end
			default: ;
		endcase
	end

	assign emit_ok = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q <= em_kind;
			out_byte_q <= em_byte;
			out_eol_q  <= em_eol;
			out_code_q <= em_code;
			out_last_q <= cmd.emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_kind    = out_kind_q;
	assign out_byte    = out_byte_q;
	assign end_of_line = out_eol_q;
	assign signal_code = out_code_q;
	assign last        = out_last_q;

	always_comb begin
		st.cls        = cls;
		st.echo_on    = local_mode_q[2];
		st.echo_nl_on = local_mode_q[2] || local_mode_q[5];
		st.main_cr    = main_byte == CH_NL && output_mode_q[0] && output_mode_q[1];
		st.out_free   = emit_ok;
		st.len_zero   = len_q == '0;
		st.len_one    = len_q == LW'(1);
		st.idx_last   = (LW'(idx_q) + LW'(1)) == len_q;
	end

endmodule

// File: rtl/tty_ld_ctrl.sv
// Controller of the line discipline: a state machine that walks one item
// through its stores, echoes, erase steps and line commit.
// Depends on tty_ld_pkg; commands tty_ld_dp and reads its status.
`timescale 1ns / 1ps

module tty_ld_ctrl import tty_ld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SIG,
		ST_RAW,
		ST_STA,
		ST_STB,
		ST_CARET,
		ST_CR,
		ST_MAIN,
		ST_COMMIT,
		ST_BS1,
		ST_SP,
		ST_BS2
	} state_t;

	state_t         state_q, state_d;
	logic           stb_q, stb_d;
	logic           caret_q, caret_d;
	logic           cr_q, cr_d;
	logic           main_q, main_d;
	logic           commit_q, commit_d;
	logic           kill_q, kill_d;
	logic [ECW-1:0] erase_cnt_q, erase_cnt_d;
	logic           cap;
	logic           erase_done;
	logic           main_on;

	assign in_stall   = state_q != ST_IDLE;
	assign cap        = erase_cnt_q == ECW'(ERASE_CAP - 1);
	assign erase_done = !kill_q || st.len_one || cap;

	always_comb begin
		main_on = ((st.cls == CL_RAW || st.cls == CL_CTRL || st.cls == CL_PLAIN) && st.echo_on)
			|| (st.cls == CL_NL && st.echo_nl_on);
	end

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		stb_d       = stb_q;
		caret_d     = caret_q;
		cr_d        = cr_q;
		main_d      = main_q;
		commit_d    = commit_q;
		kill_d      = kill_q;
		erase_cnt_d = erase_cnt_q;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_DECODE;
				end
			end
			ST_DECODE: begin
				stb_d         = st.cls == CL_CTRL;
				caret_d       = st.cls == CL_CTRL && st.echo_on;
				main_d        = main_on;
				cr_d          = main_on && st.main_cr;
				commit_d      = st.cls == CL_EOF || st.cls == CL_NL || st.cls == CL_EOL;
				kill_d        = st.cls == CL_KILL;
				erase_cnt_d   = '0;
				cmd.idx_clear = 1'b1;
				case (st.cls)
					CL_FLUSH: begin
						cmd.len_clear = 1'b1;
						state_d       = ST_IDLE;
					end
					CL_SIG:   state_d = ST_SIG;
					CL_RAW:   state_d = ST_RAW;
					CL_KILL, CL_ERASE: state_d = st.len_zero ? ST_IDLE : ST_BS1;
					CL_EOL:   state_d = st.len_zero ? ST_IDLE : ST_COMMIT;
					default:  state_d = ST_STA;
				endcase
			end
			ST_SIG: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EM_SIG;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_RAW: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EM_RAW;
					cmd.emit_last = !cr_q && !main_q;
					state_d       = ST_CR;
				end
			end
			ST_STA: begin
				cmd.store_first = 1'b1;
				state_d         = ST_STB;
			end
			ST_STB: begin
				cmd.store_second = stb_q;
				state_d          = ST_CARET;
			end
			ST_CARET: begin
				if (!caret_q) begin
					state_d = ST_CR;
				end else if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_CARET;
					state_d      = ST_CR;
				end
			end
			ST_CR: begin
				if (!cr_q) begin
					state_d = ST_MAIN;
				end else if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_CR;
					state_d      = ST_MAIN;
				end
			end
			ST_MAIN: begin
				if (!main_q) begin
					state_d = ST_COMMIT;
				end else if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EM_MAIN;
					cmd.emit_last = !commit_q;
					state_d       = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (!commit_q) begin
					state_d = ST_IDLE;
				end else if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EM_COMMIT;
					cmd.emit_last = st.idx_last;
					if (st.idx_last) begin
						cmd.len_clear = 1'b1;
						state_d       = ST_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			ST_BS1: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_BS;
					state_d      = ST_SP;
				end
			end
			ST_SP: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_SP;
					state_d      = ST_BS2;
				end
			end
			ST_BS2: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EM_BS;
					cmd.emit_last = erase_done;
					// Once the result limit is reached, a kill still empties the line.
					if (kill_q && cap) begin
						cmd.len_clear = 1'b1;
					end else begin
						cmd.len_dec = 1'b1;
					end
					if (erase_done) begin
						state_d = ST_IDLE;
					end else begin
						erase_cnt_d = erase_cnt_q + ECW'(1);
						state_d     = ST_BS1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stb_q       <= 1'b0;
			caret_q     <= 1'b0;
			cr_q        <= 1'b0;
			main_q      <= 1'b0;
			commit_q    <= 1'b0;
			kill_q      <= 1'b0;
			erase_cnt_q <= '0;
		end else begin
			state_q     <= state_d;
			stb_q       <= stb_d;
			caret_q     <= caret_d;
			cr_q        <= cr_d;
			main_q      <= main_d;
			commit_q    <= commit_d;
			kill_q      <= kill_d;
			erase_cnt_q <= erase_cnt_d;
		end
	end

endmodule

// File: rtl/tty_canonical_line_discipline_core.sv
// Terminal input line discipline. An item is accepted only while the controller is idle.
// A signal, raw byte, erase, kill or end of line goes from decode straight to its first
// result; the store path runs decode, two store steps, then the caret, carriage return,
// echo and commit steps. An item is done before another one is taken, and output stalls
// hold the flow; a kill of 16 entries (48 results) takes longest. Reset restores the default
// configuration and empties the line; store contents stay undefined until written.
`timescale 1ns / 1ps

module tty_canonical_line_discipline_core import tty_ld_pkg::*; #(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           out_kind,
	output logic [7:0]           out_byte,
	output logic                 end_of_line,
	output logic [1:0]           signal_code,
	output logic                 last
);

	dp_cmd_t    cmd;
	dp_status_t st;

	assign cfg_ready = 1'b1;

	tty_ld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	tty_ld_dp #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_type    (req_type),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_kind    (out_kind),
		.out_byte    (out_byte),
		.end_of_line (end_of_line),
		.signal_code (signal_code),
		.last        (last),
		.cmd         (cmd),
		.st          (st)
	);

endmodule
